[hdl/dppi_pkg.sv]
// Package for the decayed pair projection indicator: widths, codes, types, helpers.
`timescale 1ns / 1ps
package dppi_pkg;

  // Fixed-point and field widths
  localparam int FRAC_BITS = 16;
  localparam int DECAY_W   = 16;
  localparam int PRICE_W   = 24;
  localparam int PST_W     = 26;
  localparam int AVG_S_W   = 48;
  localparam int AVG_W     = 64;
  localparam int MAG_B_W   = 49;
  localparam int PROD_W    = AVG_W + MAG_B_W;
  localparam int ACC_W     = AVG_W + 1 + DECAY_W;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd52016;
  localparam logic [AVG_W-1:0]   Q_ONE       = 64'd1 << FRAC_BITS;
  localparam logic [AVG_W-1:0]   S64_MAX     = {1'b0, {63{1'b1}}};
  localparam logic [AVG_W-1:0]   S64_MIN     = {1'b1, 63'd0};

  // Command codes
  typedef enum logic [1:0] {
    CMD_MARKET    = 2'd0,
    CMD_INTERRUPT = 2'd1,
    CMD_RESUME    = 2'd2
  } cmd_e;

  // Top-level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_INIT,
    ST_LOAD,
    ST_EMA,
    ST_UPD,
    ST_DEV,
    ST_CHK,
    ST_MD,
    ST_PROJ,
    ST_SUB,
    ST_OUT
  } state_e;

  // Serial multiply-divide sequencer
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic               start;
    logic [AVG_W-1:0]   mag_a;
    logic [MAG_B_W-1:0] mag_b;
    logic [AVG_W-1:0]   den;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quot;
  } md_rsp_t;

  // (a*b) << FRAC_BITS with sign applied, saturated to signed 64 bit
  function automatic logic [AVG_W-1:0] prod_q(input logic [PST_W-1:0] mag_a,
                                               input logic [PST_W-1:0] mag_b,
                                               input logic             neg);
    logic [2*PST_W-1:0] mag;
    logic [AVG_W-1:0]   mag64;
    logic [AVG_W-1:0]   val;
    mag   = mag_a * mag_b;
    mag64 = AVG_W'(mag);
    if ((mag64 >> (63 - FRAC_BITS)) != '0) begin
      val = neg ? S64_MIN : S64_MAX;
    end else begin
      val = mag64 << FRAC_BITS;
      if (neg) begin
        val = -val;
      end
    end
    return val;
  endfunction

endpackage

[hdl/dppi_stream_if.sv]
// Valid/ready stream interfaces for the indicator input and result channels.
`timescale 1ns / 1ps
interface dppi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        source;
  logic [23:0] price;
  logic        books_nonempty;
  logic        sources_ready;

  modport source_mp (output valid, cmd, source, price, books_nonempty, sources_ready,
                     input ready);
  modport sink (input valid, cmd, source, price, books_nonempty, sources_ready,
                output ready);
endinterface

interface dppi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] indicator_value;

  modport source_mp (output valid, indicator_value, input ready);
  modport sink (input valid, indicator_value, output ready);
endinterface

[hdl/dppi_muldiv.sv]
// Bit-serial unsigned multiply (64 x 49) followed, unless the quotient overflows, by restoring divide of the product.
`timescale 1ns / 1ps
module dppi_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dppi_pkg::md_req_t req_i,
  output dppi_pkg::md_rsp_t rsp_o
);

  dppi_pkg::md_state_e state_q, state_d;

  logic [dppi_pkg::PROD_W-1:0]  a_sh_q;
  logic [dppi_pkg::MAG_B_W-1:0] b_sh_q;
  logic [dppi_pkg::PROD_W-1:0]  prod_q;
  logic [dppi_pkg::AVG_W-1:0]   den_q;
  logic [dppi_pkg::AVG_W-1:0]   rem_q;
  logic [dppi_pkg::AVG_W-1:0]   lo_q;
  logic [dppi_pkg::AVG_W-1:0]   quot_q;
  logic [5:0]                   cnt_q;

  logic [dppi_pkg::AVG_W-1:0] hi_c;
  logic                       ovf_c;
  logic [dppi_pkg::AVG_W:0]   r2_c;
  logic                       ge_c;

  // Overflow check and one divide step
  always_comb begin
    hi_c  = dppi_pkg::AVG_W'(prod_q[dppi_pkg::PROD_W-1:dppi_pkg::AVG_W]);
    ovf_c = hi_c >= den_q;
    r2_c  = {rem_q, lo_q[dppi_pkg::AVG_W-1]};
    ge_c  = r2_c >= {1'b0, den_q};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dppi_pkg::MD_IDLE: if (req_i.start) state_d = dppi_pkg::MD_MUL;
      dppi_pkg::MD_MUL:  if (cnt_q == 6'(dppi_pkg::MAG_B_W - 1)) state_d = dppi_pkg::MD_CHK;
      dppi_pkg::MD_CHK:  state_d = ovf_c ? dppi_pkg::MD_DONE : dppi_pkg::MD_DIV;
      dppi_pkg::MD_DIV:  if (cnt_q == 6'(dppi_pkg::AVG_W - 1)) state_d = dppi_pkg::MD_DONE;
      dppi_pkg::MD_DONE: state_d = dppi_pkg::MD_IDLE;
      default:           state_d = dppi_pkg::MD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done = (state_q == dppi_pkg::MD_DONE);
    rsp_o.quot = quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dppi_pkg::MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: shift-add multiply, then, unless the high half overflows, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      dppi_pkg::MD_IDLE: begin
        a_sh_q <= dppi_pkg::PROD_W'(req_i.mag_a);
        b_sh_q <= req_i.mag_b;
        den_q  <= req_i.den;
        prod_q <= '0;
        cnt_q  <= '0;
      end
      dppi_pkg::MD_MUL: begin
        if (b_sh_q[0]) prod_q <= prod_q + a_sh_q;
        a_sh_q <= a_sh_q << 1;
        b_sh_q <= b_sh_q >> 1;
        cnt_q  <= cnt_q + 6'd1;
      end
      dppi_pkg::MD_CHK: begin
        rem_q  <= hi_c;
        lo_q   <= prod_q[dppi_pkg::AVG_W-1:0];
        quot_q <= ovf_c ? dppi_pkg::S64_MIN : '0;
        cnt_q  <= '0;
      end
      dppi_pkg::MD_DIV: begin
        if (ge_c) begin
          rem_q <= dppi_pkg::AVG_W'(r2_c - {1'b0, den_q});
        end else begin
          rem_q <= r2_c[dppi_pkg::AVG_W-1:0];
        end
        quot_q <= {quot_q[dppi_pkg::AVG_W-2:0], ge_c};
        lo_q   <= lo_q << 1;
        cnt_q  <= cnt_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/decayed_pair_projection_indicator_top.sv]
// Top level of the decayed pair projection indicator.
`timescale 1ns / 1ps
// Usage:
//   in_ch_i carries one update (cmd, source, price, books_nonempty, sources_ready);
//   a transfer happens when valid and ready are high at a rising clock edge.
//   out_ch_o carries the indicator value in signed Q16, at most one per update.
//   cfg_we_i/cfg_wdata_i write the decay factor (Q0.16); write it
//   only while the block is idle.
// Timing:
//   One item is worked on at a time; ready is high only in the idle state.
//   A full market update runs bit-serial decay over the four averages, then a
//   serial multiply and, unless the quotient would overflow, a serial divide in
//   the multiply-divide unit, plus control steps.
// Reset:
//   rst_ni clears all prices, averages, flags and the last value; the decay
//   factor returns to 52016.
// Stalls:
//   A result sits in the output register until taken; the block takes the next
//   item meanwhile, and waits before delivering its result only if that
//   register is still full.
module decayed_pair_projection_indicator_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  dppi_in_if.sink         in_ch_i,
  dppi_out_if.source_mp   out_ch_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);

  localparam int LANE_DEP   = 0;
  localparam int LANE_IND   = 1;
  localparam int LANE_CROSS = 2;
  localparam int LANE_SQ    = 3;
  localparam int LANES      = 4;

  dppi_pkg::state_e state_q, state_d;

  // Architectural state
  logic [dppi_pkg::DECAY_W-1:0] decay_q;
  logic [dppi_pkg::PST_W-1:0]   dep_q, indep_q, mirror_q;
  logic [dppi_pkg::AVG_S_W-1:0] avg_dep_q, avg_ind_q;
  logic [dppi_pkg::AVG_W-1:0]   avg_cross_q, avg_sq_q, last_q;
  logic                         ready_q;
  logic [2:0]                   intr_q;
  logic                         init_q, init_res_q;

  // Working registers
  logic [dppi_pkg::AVG_W-1:0]   smp_q  [LANES];
  logic [dppi_pkg::ACC_W-1:0]   diff_q [LANES];
  logic [dppi_pkg::ACC_W-1:0]   acc_q  [LANES];
  logic [dppi_pkg::DECAY_W-1:0] dsh_q;
  logic [3:0]                   cnt_q;
  logic [dppi_pkg::AVG_W-1:0]   ind_dev_q, dep_dev_q, proj_q;
  logic                         neg_q;
  logic                         out_valid_q;
  logic [dppi_pkg::AVG_W-1:0]   out_val_q;

  dppi_pkg::md_req_t md_req;
  dppi_pkg::md_rsp_t md_rsp;

  logic                       accept_c, out_load_c, sq_big_c;
  logic [2:0]                 intr_clr_c;
  logic [dppi_pkg::PST_W-1:0] mirror_use_c, m_c, mag_m_c;
  logic [dppi_pkg::AVG_W-1:0] avg_ext_c [LANES];
  logic [dppi_pkg::AVG_W-1:0] ema_c     [LANES];
  logic [dppi_pkg::AVG_W-1:0] ind_dev_c, dep_dev_c;
  logic [dppi_pkg::AVG_W-1:0] mag_p_c, mag_d_c, sub_c;
  logic [dppi_pkg::AVG_W:0]   s65_c;

  // Mirrored independent value and helpers
  always_comb begin
    mirror_use_c = init_q ? {indep_q[dppi_pkg::PST_W-2:0], 1'b0} : mirror_q;
    m_c          = mirror_use_c - indep_q;
    mag_m_c      = m_c[dppi_pkg::PST_W-1] ? -m_c : m_c;
    intr_clr_c   = intr_q & ~(in_ch_i.source ? 3'b010 : 3'b001);
    sq_big_c     = $signed(avg_sq_q) > $signed(dppi_pkg::Q_ONE);
    avg_ext_c[LANE_DEP]   = {{16{avg_dep_q[dppi_pkg::AVG_S_W-1]}}, avg_dep_q};
    avg_ext_c[LANE_IND]   = {{16{avg_ind_q[dppi_pkg::AVG_S_W-1]}}, avg_ind_q};
    avg_ext_c[LANE_CROSS] = avg_cross_q;
    avg_ext_c[LANE_SQ]    = avg_sq_q;
    for (int k = 0; k < LANES; k++) begin
      ema_c[k] = dppi_pkg::AVG_W'(smp_q[k] + acc_q[k][dppi_pkg::ACC_W-1:dppi_pkg::DECAY_W]);
    end
    ind_dev_c = smp_q[LANE_IND] - avg_ext_c[LANE_IND];
    dep_dev_c = smp_q[LANE_DEP] - avg_ext_c[LANE_DEP];
  end

  // Final compare and saturating subtract
  always_comb begin
    mag_p_c = proj_q[dppi_pkg::AVG_W-1] ? -proj_q : proj_q;
    mag_d_c = dep_dev_q[dppi_pkg::AVG_W-1] ? -dep_dev_q : dep_dev_q;
    s65_c   = {proj_q[dppi_pkg::AVG_W-1], proj_q} - {dep_dev_q[dppi_pkg::AVG_W-1], dep_dev_q};
    if (mag_p_c <= mag_d_c) begin
      sub_c = '0;
    end else if (s65_c[dppi_pkg::AVG_W] != s65_c[dppi_pkg::AVG_W-1]) begin
      sub_c = s65_c[dppi_pkg::AVG_W] ? dppi_pkg::S64_MIN : dppi_pkg::S64_MAX;
    end else begin
      sub_c = s65_c[dppi_pkg::AVG_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dppi_pkg::ST_IDLE: begin
        if (in_ch_i.valid) begin
          case (in_ch_i.cmd)
            dppi_pkg::CMD_MARKET: begin
              if (!in_ch_i.books_nonempty) state_d = dppi_pkg::ST_IDLE;
              else if (!ready_q)
                state_d = in_ch_i.sources_ready ? dppi_pkg::ST_PROD : dppi_pkg::ST_OUT;
              else if (intr_q[2]) state_d = dppi_pkg::ST_OUT;
              else state_d = dppi_pkg::ST_PROD;
            end
            dppi_pkg::CMD_INTERRUPT: state_d = dppi_pkg::ST_OUT;
            dppi_pkg::CMD_RESUME: begin
              if (intr_q[2] && (intr_clr_c[1:0] == 2'b00)) state_d = dppi_pkg::ST_PROD;
            end
            default: state_d = dppi_pkg::ST_IDLE;
          endcase
        end
      end
      dppi_pkg::ST_PROD: state_d = init_q ? dppi_pkg::ST_INIT : dppi_pkg::ST_LOAD;
      dppi_pkg::ST_INIT: state_d = init_res_q ? dppi_pkg::ST_OUT : dppi_pkg::ST_IDLE;
      dppi_pkg::ST_LOAD: state_d = dppi_pkg::ST_EMA;
      dppi_pkg::ST_EMA:  if (cnt_q == 4'(dppi_pkg::DECAY_W - 1)) state_d = dppi_pkg::ST_UPD;
      dppi_pkg::ST_UPD:  state_d = dppi_pkg::ST_DEV;
      dppi_pkg::ST_DEV:  state_d = dppi_pkg::ST_CHK;
      dppi_pkg::ST_CHK:  state_d = sq_big_c ? dppi_pkg::ST_MD : dppi_pkg::ST_OUT;
      dppi_pkg::ST_MD:   if (md_rsp.done) state_d = dppi_pkg::ST_PROJ;
      dppi_pkg::ST_PROJ: state_d = dppi_pkg::ST_SUB;
      dppi_pkg::ST_SUB:  state_d = dppi_pkg::ST_OUT;
      dppi_pkg::ST_OUT:  if (out_load_c) state_d = dppi_pkg::ST_IDLE;
      default:           state_d = dppi_pkg::ST_IDLE;
    endcase
  end

  // Outputs and control strobes
  always_comb begin
    in_ch_i.ready            = (state_q == dppi_pkg::ST_IDLE);
    accept_c                 = in_ch_i.ready && in_ch_i.valid;
    out_load_c               = (state_q == dppi_pkg::ST_OUT) && (!out_valid_q || out_ch_o.ready);
    out_ch_o.valid           = out_valid_q;
    out_ch_o.indicator_value = out_val_q;
    md_req.start = (state_q == dppi_pkg::ST_CHK) && sq_big_c;
    md_req.mag_a = avg_cross_q[dppi_pkg::AVG_W-1] ? -avg_cross_q : avg_cross_q;
    md_req.mag_b = dppi_pkg::MAG_B_W'(ind_dev_q[dppi_pkg::AVG_W-1] ? -ind_dev_q : ind_dev_q);
    md_req.den   = avg_sq_q;
  end

  dppi_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Sequencer state, architectural state, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dppi_pkg::ST_IDLE;
      decay_q     <= dppi_pkg::DECAY_RESET;
      dep_q       <= '0;
      indep_q     <= '0;
      mirror_q    <= '0;
      avg_dep_q   <= '0;
      avg_ind_q   <= '0;
      avg_cross_q <= '0;
      avg_sq_q    <= '0;
      last_q      <= '0;
      ready_q     <= 1'b0;
      intr_q      <= '0;
      init_q      <= 1'b0;
      init_res_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) decay_q <= cfg_wdata_i;

      // Result register: load when free or being taken
      if (out_load_c) out_valid_q <= 1'b1;
      else if (out_ch_o.ready) out_valid_q <= 1'b0;

      // Item transfer
      if (accept_c) begin
        case (in_ch_i.cmd)
          dppi_pkg::CMD_MARKET: begin
            if (in_ch_i.source) indep_q <= dppi_pkg::PST_W'(in_ch_i.price);
            else dep_q <= dppi_pkg::PST_W'(in_ch_i.price);
            init_q     <= !ready_q;
            init_res_q <= 1'b1;
            if (in_ch_i.books_nonempty && !ready_q && in_ch_i.sources_ready) ready_q <= 1'b1;
          end
          dppi_pkg::CMD_INTERRUPT: begin
            intr_q <= intr_q | (in_ch_i.source ? 3'b110 : 3'b101);
            last_q <= '0;
          end
          dppi_pkg::CMD_RESUME: begin
            if (intr_q[2]) begin
              if (intr_clr_c[1:0] == 2'b00) begin
                intr_q     <= '0;
                init_q     <= 1'b1;
                init_res_q <= 1'b0;
              end else begin
                intr_q <= intr_clr_c;
              end
            end
          end
          default: begin
          end
        endcase
      end

      case (state_q)
        dppi_pkg::ST_PROD: if (init_q) mirror_q <= mirror_use_c;
        dppi_pkg::ST_INIT: begin
          avg_dep_q   <= smp_q[LANE_DEP][dppi_pkg::AVG_S_W-1:0];
          avg_ind_q   <= smp_q[LANE_IND][dppi_pkg::AVG_S_W-1:0];
          avg_cross_q <= smp_q[LANE_CROSS];
          avg_sq_q    <= smp_q[LANE_SQ];
          last_q      <= '0;
        end
        dppi_pkg::ST_UPD: begin
          avg_dep_q   <= ema_c[LANE_DEP][dppi_pkg::AVG_S_W-1:0];
          avg_ind_q   <= ema_c[LANE_IND][dppi_pkg::AVG_S_W-1:0];
          avg_cross_q <= ema_c[LANE_CROSS];
          avg_sq_q    <= ema_c[LANE_SQ];
        end
        dppi_pkg::ST_CHK: if (!sq_big_c) last_q <= '0;
        dppi_pkg::ST_SUB: last_q <= sub_c;
        default: begin
        end
      endcase
    end
  end

  // Working datapath: samples, serial decay lanes, deviations, projection
  always_ff @(posedge clk_i) begin
    if (out_load_c) out_val_q <= last_q;
    case (state_q)
      dppi_pkg::ST_PROD: begin
        smp_q[LANE_DEP]   <= dppi_pkg::AVG_W'(dep_q) << dppi_pkg::FRAC_BITS;
        smp_q[LANE_IND]   <= {{(dppi_pkg::AVG_W-dppi_pkg::PST_W){m_c[dppi_pkg::PST_W-1]}}, m_c}
                             << dppi_pkg::FRAC_BITS;
        smp_q[LANE_CROSS] <= dppi_pkg::prod_q(dep_q, mag_m_c, m_c[dppi_pkg::PST_W-1]);
        smp_q[LANE_SQ]    <= dppi_pkg::prod_q(mag_m_c, mag_m_c, 1'b0);
      end
      dppi_pkg::ST_LOAD: begin
        for (int k = 0; k < LANES; k++) begin
          diff_q[k] <= {{(dppi_pkg::ACC_W-dppi_pkg::AVG_W){avg_ext_c[k][dppi_pkg::AVG_W-1]}},
                        avg_ext_c[k]}
                     - {{(dppi_pkg::ACC_W-dppi_pkg::AVG_W){smp_q[k][dppi_pkg::AVG_W-1]}},
                        smp_q[k]};
          acc_q[k]  <= '0;
        end
        dsh_q <= decay_q;
        cnt_q <= '0;
      end
      dppi_pkg::ST_EMA: begin
        // One decay bit per cycle: acc += bit ? (avg - x) << i
        for (int k = 0; k < LANES; k++) begin
          if (dsh_q[0]) acc_q[k] <= acc_q[k] + diff_q[k];
          diff_q[k] <= diff_q[k] << 1;
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q + 4'd1;
      end
      dppi_pkg::ST_DEV: begin
        ind_dev_q <= ind_dev_c;
        dep_dev_q <= dep_dev_c;
        neg_q     <= avg_cross_q[dppi_pkg::AVG_W-1] ^ ind_dev_c[dppi_pkg::AVG_W-1];
      end
      dppi_pkg::ST_PROJ: begin
        if (neg_q) proj_q <= md_rsp.quot[dppi_pkg::AVG_W-1] ? dppi_pkg::S64_MIN : -md_rsp.quot;
        else proj_q <= md_rsp.quot[dppi_pkg::AVG_W-1] ? dppi_pkg::S64_MAX : md_rsp.quot;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_src_bits_imply_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (intr_q[1:0] != 2'b00) |-> intr_q[2])
    else $error("source interrupt bit set without data interrupted bit");

  a_md_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
      md_rsp.done |-> (state_q == dppi_pkg::ST_MD))
    else $error("multiply-divide finished outside its wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> ($past(state_q) == dppi_pkg::ST_OUT))
    else $error("result appeared without passing the output step");

endmodule

[sim/dppi_checker.sv]
// Checker for the decayed pair projection indicator: watches both channels, predicts, compares.
`timescale 1ns / 1ps
module dppi_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic        source_i,
  input  logic [23:0] price_i,
  input  logic        books_i,
  input  logic        srdy_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] value_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  localparam longint S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S_MIN = 64'sh8000_0000_0000_0000;
  localparam longint A48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint A48_MIN = -A48_MAX - 1;

  // Predictor state
  logic [15:0] decay;
  longint dep_px, ind_px, mirror_ref;
  longint a_dep, a_ind, a_cross, a_sq, last_val;
  bit     is_ready;
  bit [2:0] intr;
  longint expected_values[$];
  int     fails;

  assign fail_count_o   = fails;

  function automatic longint sat_mag(bit neg, logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000_0000_0000) ? S_MIN : -longint'(mag);
    return (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? S_MAX : longint'(mag);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > A48_MAX) return A48_MAX;
    if (v < A48_MIN) return A48_MIN;
    return v;
  endfunction

  function automatic longint scaled_product(longint a, longint b);
    logic [63:0] mag;
    bit neg;
    mag = abs64(a) * abs64(b);
    neg = (a < 0) != (b < 0);
    if ((mag >> (63 - dppi_pkg::FRAC_BITS)) != 0)
      return sat_mag(neg, 64'h8000_0000_0000_0000);
    return sat_mag(neg, mag << dppi_pkg::FRAC_BITS);
  endfunction

  // Exact floor((x*w + avg*d) / 2^16), saturated to 64 bit
  function automatic longint decayed(longint x, longint avg);
    logic signed [95:0] acc;
    acc = 96'(signed'(x)) * $signed({79'd0, 17'd65536 - {1'b0, decay}})
        + 96'(signed'(avg)) * $signed({80'd0, decay});
    acc = acc >>> 16;
    if (acc > 96'(signed'(S_MAX))) return S_MAX;
    if (acc < 96'(signed'(S_MIN))) return S_MIN;
    return longint'(acc);
  endfunction

  function automatic longint projection(longint a, longint b, longint den);
    logic [127:0] prod, q;
    bit neg;
    neg = (a < 0) != (b < 0);
    prod = 128'(abs64(a)) * 128'(abs64(b));
    q = prod / 128'(den);
    if (q[127:63] != 0) return sat_mag(neg, 64'h8000_0000_0000_0000);
    return sat_mag(neg, q[63:0]);
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) - 65'(signed'(b));
    if (s > 65'(signed'(S_MAX))) return S_MAX;
    if (s < 65'(signed'(S_MIN))) return S_MIN;
    return longint'(s);
  endfunction

  task automatic reinit();
    longint m;
    mirror_ref = 2 * ind_px;
    m = mirror_ref - ind_px;
    a_dep = clamp48(dep_px <<< dppi_pkg::FRAC_BITS);
    a_ind = clamp48(m <<< dppi_pkg::FRAC_BITS);
    a_cross = scaled_product(dep_px, m);
    a_sq = scaled_product(m, m);
    last_val = 0;
  endtask

  function automatic longint next_indicator();
    longint m, xd, xi, ind_dev, dep_dev, proj;
    m = mirror_ref - ind_px;
    xd = dep_px <<< dppi_pkg::FRAC_BITS;
    xi = m <<< dppi_pkg::FRAC_BITS;
    a_dep = clamp48(decayed(xd, a_dep));
    a_ind = clamp48(decayed(xi, a_ind));
    a_cross = decayed(scaled_product(dep_px, m), a_cross);
    a_sq = decayed(scaled_product(m, m), a_sq);
    if (a_sq <= (longint'(1) <<< dppi_pkg::FRAC_BITS)) return 0;
    ind_dev = xi - a_ind;
    dep_dev = xd - a_dep;
    proj = projection(a_cross, ind_dev, a_sq);
    if (abs64(proj) > abs64(dep_dev)) return sat_diff(proj, dep_dev);
    return 0;
  endfunction

  task automatic apply_update(logic [1:0] cmd, logic src, logic [23:0] px, logic bk,
                              logic sr);
    case (cmd)
      dppi_pkg::CMD_MARKET: begin
        if (src) ind_px = px; else dep_px = px;
        if (bk) begin
          if (!is_ready) begin
            if (sr) begin
              is_ready = 1;
              reinit();
            end
          end else if (!intr[2]) begin
            last_val = next_indicator();
          end
          expected_values.push_back(last_val);
        end
      end
      dppi_pkg::CMD_INTERRUPT: begin
        intr |= src ? 3'b110 : 3'b101;
        last_val = 0;
        expected_values.push_back(0);
      end
      dppi_pkg::CMD_RESUME: begin
        if (intr[2]) begin
          intr[src] = 1'b0;
          if (intr[1:0] == 2'b00) begin
            reinit();
            intr = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Track transfers on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay = dppi_pkg::DECAY_RESET;
      dep_px = 0; ind_px = 0; mirror_ref = 0;
      a_dep = 0; a_ind = 0; a_cross = 0; a_sq = 0; last_val = 0;
      is_ready = 0; intr = '0;
      expected_values.delete();
      fails = 0;
      result_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) decay = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (expected_values.size() == 0) report_mismatch("unexpected result", value_i, 0);
        else begin
          longint want;
          want = expected_values.pop_front();
          if (longint'(value_i) !== want) report_mismatch("indicator_value", value_i, want);
        end
      end
      if (in_valid_i && in_ready_i) apply_update(cmd_i, source_i, price_i, books_i, srdy_i);
      pending_o = expected_values.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the decayed pair projection indicator: stimulus, clock, reset, verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 3_000_000;
  // Command code the block must ignore
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int   send_idle_pct, recv_idle_pct;
  int   cycles;
  int   fail_count, pending, result_count, updates_sent;

  dppi_in_if  in_ch();
  dppi_out_if out_ch();

  always #6 clk_i = ~clk_i;

  decayed_pair_projection_indicator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch.sink),
    .out_ch_o   (out_ch.source_mp),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  dppi_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .cmd_i(in_ch.cmd), .source_i(in_ch.source), .price_i(in_ch.price),
    .books_i(in_ch.books_nonempty), .srdy_i(in_ch.sources_ready),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .value_i(out_ch.indicator_value),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = dppi_pkg::CMD_MARKET;
    in_ch.source = 1'b0;
    in_ch.price = '0;
    in_ch.books_nonempty = 1'b0;
    in_ch.sources_ready = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("decayed_pair_projection_indicator_top regression: fail");
      $finish;
    end
  end

  // One transfer on the input channel, with random idle cycles ahead of it
  task automatic send_update(logic [1:0] cmd, logic src, logic [23:0] px, logic bk,
                             logic sr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.source <= src;
    in_ch.price <= px;
    in_ch.books_nonempty <= bk;
    in_ch.sources_ready <= sr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    updates_sent++;
  endtask

  task automatic drain_and_write(logic [15:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Prices mostly near a level so the averages stay meaningful, sometimes anywhere
  function automatic logic [23:0] pick_price(logic [23:0] level);
    if ($urandom_range(9) == 0) return 24'($urandom);
    return level + 24'($urandom_range(64)) - 24'd32;
  endfunction

  task automatic random_phase(int count);
    logic [23:0] lvl_dep, lvl_ind;
    int r;
    lvl_dep = 24'($urandom_range(200, 50000));
    lvl_ind = 24'($urandom_range(200, 50000));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 82) begin
        logic s;
        s = $urandom_range(1);
        send_update(dppi_pkg::CMD_MARKET, s, pick_price(s ? lvl_ind : lvl_dep),
                    $urandom_range(15) != 0, $urandom_range(7) != 0);
      end else if (r < 89) begin
        send_update(dppi_pkg::CMD_INTERRUPT, $urandom_range(1), 24'($urandom),
                    $urandom_range(1), $urandom_range(1));
      end else if (r < 98) begin
        send_update(dppi_pkg::CMD_RESUME, $urandom_range(1), 24'($urandom),
                    $urandom_range(1), $urandom_range(1));
      end else begin
        send_update(CMD_UNKNOWN, $urandom_range(1), 24'($urandom), $urandom_range(1),
                    $urandom_range(1));
      end
    end
  endtask

  initial begin
    cycles = 0;
    updates_sent = 0;
    send_idle_pct = 11;
    recv_idle_pct = 79;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty books, not ready, becoming ready, extremes, interrupts, resumes
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'd1000, 1'b0, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd900, 1'b1, 1'b0);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd900, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'd1010, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd890, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'hFFFFFF, 1'b1, 1'b0);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'hFFFFFF, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd0, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'd0, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_RESUME, 1'b0, 24'd5, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_INTERRUPT, 1'b0, 24'd0, 1'b0, 1'b0);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'd1200, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_INTERRUPT, 1'b1, 24'hFFFFFF, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_RESUME, 1'b0, 24'd0, 1'b0, 1'b0);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd800, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_RESUME, 1'b1, 24'd0, 1'b0, 1'b0);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'd1300, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b1, 24'd700, 1'b1, 1'b1);
    send_update(CMD_UNKNOWN, 1'b1, 24'hABCDEF, 1'b1, 1'b1);
    send_update(dppi_pkg::CMD_MARKET, 1'b0, 24'h800000, 1'b1, 1'b1);

    drain_and_write(16'd0);
    random_phase(200);
    drain_and_write(16'hFFFF);
    random_phase(200);
    send_idle_pct = 79;
    recv_idle_pct = 11;
    drain_and_write(16'd32768);
    random_phase(350);
    drain_and_write(16'($urandom));
    random_phase(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_write(dppi_pkg::DECAY_RESET);
    random_phase(400);
    drain_and_write(16'd1);
    random_phase(230);

    // Let everything drain
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d updates over six decay settings and three stall mixes.", updates_sent);
    $display("Checked %0d indicator results.", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("decayed_pair_projection_indicator_top regression: pass");
    end else begin
      $display("decayed_pair_projection_indicator_top regression: fail");
    end
    $finish;
  end

endmodule
